FILE: rtl/sbq_pkg.sv
// Shared types and codes for the semaphore block queue table.
`timescale 1ns / 1ps
package sbq_pkg;

    localparam int KEY_W  = 32;
    localparam int PROC_W = 5;
    localparam int NPROC  = 32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_OUT    = 2'd2;
    localparam logic [1:0] MODE_PEEK   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_UNUSED    = 2'd3;

    typedef logic [PROC_W-1:0] t_proc;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        t_proc            head;
        t_proc            tail;
    } t_slot_word;

    typedef struct packed {
        logic  en;
        t_proc addr;
        t_proc data;
    } t_link_wr;

    typedef struct packed {
        logic [1:0] status;
        logic       valid;
        t_proc      pid;
    } t_result;

endpackage

FILE: rtl/sbq_slot_ram.sv
// Semaphore slot memory: key, queue head and queue tail for each slot.
`timescale 1ns / 1ps
module sbq_slot_ram #(
    parameter int DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output sbq_pkg::t_slot_word          o_rd_data,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  sbq_pkg::t_slot_word          i_wr_data
);
    import sbq_pkg::*;

    t_slot_word r_mem [DEPTH];
    t_slot_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sbq_link_ram.sv
// Process link memory: the next process in the same wait queue.
`timescale 1ns / 1ps
module sbq_link_ram (
    input  logic              i_clk,
    input  sbq_pkg::t_proc    i_rd_addr,
    output sbq_pkg::t_proc    o_rd_data,
    input  sbq_pkg::t_link_wr i_wr
);
    import sbq_pkg::*;

    t_proc r_mem [NPROC];
    t_proc r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/semaphore_block_queue_table.sv
// Top level of the semaphore block queue table: control sequencer and result register.
`timescale 1ns / 1ps
// The block keeps up to NUM_ENTRIES active semaphores, each named by a 32-bit key and
// holding a FIFO of blocked process ids (0 to 31). One input beat carries a mode, a key
// and a process id, and every input beat yields exactly one result beat. Slot keys, heads
// and tails live in a slot memory, queue links in a link memory, both with registered
// reads; active bits per slot and waiting bits per process are flip-flops that reset
// clears, so no clearing pass is needed and the block is ready right after reset.
// Insert, remove and peek search the slot memory for the key one slot at a time, reading
// in S_SCAN and comparing in S_CMP and stopping at a match; the decision state S_DEC and
// the handoff state S_FIN follow, and the block then returns to idle. Remove and out
// then unlink a process in S_UNLINK, followed by S_TRD and S_TWR when the queue does
// not empty; for a process behind the head, the walk along the link memory through
// S_WRD and S_WCMP comes first. Out needs no search and reads the slot of its process in
// S_ORD and S_OCMP. Only one item is in progress at a time; the next input beat is taken
// once the current result has moved to the output register, even while that result
// still waits.
module semaphore_block_queue_table #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_mode,
    input  logic [sbq_pkg::KEY_W-1:0]    i_sem_key,
    input  logic [sbq_pkg::PROC_W-1:0]   i_proc_id,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic                         o_result_valid,
    output logic [sbq_pkg::PROC_W-1:0]   o_result_proc
);
    import sbq_pkg::*;

    localparam int SW = $clog2(NUM_ENTRIES);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CMP, S_DEC, S_ORD, S_OCMP,
        S_UNLINK, S_WRD, S_WCMP, S_TRD, S_TWR, S_FIN
    } t_state;

    t_state        r_state;
    logic          r_active  [NUM_ENTRIES];
    logic          r_waiting [NPROC];
    logic [SW-1:0] r_pslot   [NPROC];

    logic [1:0]       r_mode;
    logic [KEY_W-1:0] r_key;
    t_proc            r_pid;
    logic [SW-1:0]    r_idx;
    logic             r_found;
    logic [SW-1:0]    r_slot;
    logic             r_have_free;
    logic [SW-1:0]    r_free;
    t_slot_word       r_word;
    t_proc            r_tgt;
    t_proc            r_cur;
    t_proc            r_prev;
    logic             r_prev_none;
    t_result          r_res;
    t_result          r_out;
    logic             r_out_valid;

    logic          in_accept;
    logic [SW-1:0] slot_raddr;
    t_slot_word    slot_rdata;
    logic          slot_we;
    logic [SW-1:0] slot_waddr;
    t_slot_word    slot_wdata;
    t_proc         link_raddr;
    t_proc         link_rdata;
    t_link_wr      link_wr;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);

    // The out mode reads the slot its process waits in; all else reads the scan slot.
    assign slot_raddr = (r_state == S_ORD) ? r_pslot[r_pid] : r_idx;
    assign link_raddr = (r_state == S_TRD) ? r_tgt : r_cur;

    // Memory write ports. Each state writes what it learned from reads of earlier
    // states; a read that overlaps a write to the same entry is never used.
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = r_word;
        link_wr    = '0;
        case (r_state)
            S_DEC: begin
                if (r_mode == MODE_INSERT) begin
                    if (r_found) begin
                        // Append to the tail of an existing queue.
                        slot_we         = 1'b1;
                        slot_wdata.tail = r_pid;
                        link_wr.en      = 1'b1;
                        link_wr.addr    = r_word.tail;
                        link_wr.data    = r_pid;
                    end else if (r_have_free) begin
                        // Claim the lowest free slot with a one-entry queue.
                        slot_we    = 1'b1;
                        slot_waddr = r_free;
                        slot_wdata = '{key: r_key, head: r_pid, tail: r_pid};
                    end
                end
            end
            S_TWR: begin
                if (r_prev_none) begin
                    slot_we         = 1'b1;
                    slot_wdata.head = link_rdata;
                end else begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = r_prev;
                    link_wr.data = link_rdata;
                    if (r_word.tail == r_tgt) begin
                        slot_we         = 1'b1;
                        slot_wdata.tail = r_prev;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    sbq_slot_ram #(
        .DEPTH(NUM_ENTRIES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rd_addr (slot_raddr),
        .o_rd_data (slot_rdata),
        .i_we      (slot_we),
        .i_wr_addr (slot_waddr),
        .i_wr_data (slot_wdata)
    );

    sbq_link_ram u_link_ram (
        .i_clk     (i_clk),
        .i_rd_addr (link_raddr),
        .o_rd_data (link_rdata),
        .i_wr      (link_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_active[i] <= 1'b0;
            end
            for (int i = 0; i < NPROC; i++) begin
                r_waiting[i] <= 1'b0;
            end
        end else begin
            // The output register fills from the sequencer or empties on a taken beat.
            if (r_state == S_FIN && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mode      <= i_mode;
                        r_key       <= i_sem_key;
                        r_pid       <= i_proc_id;
                        r_idx       <= '0;
                        r_found     <= 1'b0;
                        r_have_free <= 1'b0;
                        r_res       <= '{status: ST_DONE, valid: 1'b0, pid: '0};
                        if (i_mode == MODE_OUT) begin
                            r_slot <= r_pslot[i_proc_id];
                            r_tgt  <= i_proc_id;
                            if (!r_waiting[i_proc_id] || !r_active[r_pslot[i_proc_id]]) begin
                                r_res.status <= ST_NOT_FOUND;
                                r_state      <= S_FIN;
                            end else begin
                                r_state <= S_ORD;
                            end
                        end else if (i_mode == MODE_INSERT && r_waiting[i_proc_id]) begin
                            // A process already blocked is ignored.
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_active[r_idx] && slot_rdata.key == r_key) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx;
                        r_word  <= slot_rdata;
                        r_state <= S_DEC;
                    end else begin
                        if (!r_active[r_idx] && !r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free      <= r_idx;
                        end
                        if (r_idx == LAST_SLOT) begin
                            r_state <= S_DEC;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_DEC: begin
                    r_state <= S_FIN;
                    if (r_mode == MODE_INSERT) begin
                        if (r_found) begin
                            r_waiting[r_pid] <= 1'b1;
                            r_pslot[r_pid]   <= r_slot;
                        end else if (r_have_free) begin
                            r_active[r_free] <= 1'b1;
                            r_waiting[r_pid] <= 1'b1;
                            r_pslot[r_pid]   <= r_free;
                        end else begin
                            r_res.status <= ST_NO_SLOT;
                        end
                    end else if (!r_found) begin
                        r_res.status <= ST_NOT_FOUND;
                    end else begin
                        r_res.valid <= 1'b1;
                        r_res.pid   <= r_word.head;
                        r_tgt       <= r_word.head;
                        if (r_mode == MODE_REMOVE) begin
                            r_state <= S_UNLINK;
                        end
                    end
                end
                S_ORD: begin
                    r_state <= S_OCMP;
                end
                S_OCMP: begin
                    r_word      <= slot_rdata;
                    r_res.valid <= 1'b1;
                    r_res.pid   <= r_tgt;
                    r_state     <= S_UNLINK;
                end
                S_UNLINK: begin
                    r_cur <= r_word.head;
                    if (r_word.head == r_tgt) begin
                        r_prev_none <= 1'b1;
                        if (r_word.tail == r_tgt) begin
                            // The queue empties: the slot returns to the free pool.
                            r_active[r_slot] <= 1'b0;
                            r_waiting[r_tgt] <= 1'b0;
                            r_state          <= S_FIN;
                        end else begin
                            r_state <= S_TRD;
                        end
                    end else begin
                        r_prev_none <= 1'b0;
                        r_state     <= S_WRD;
                    end
                end
                S_WRD: begin
                    r_state <= S_WCMP;
                end
                S_WCMP: begin
                    if (link_rdata == r_tgt) begin
                        r_prev  <= r_cur;
                        r_state <= S_TRD;
                    end else begin
                        r_cur   <= link_rdata;
                        r_state <= S_WRD;
                    end
                end
                S_TRD: begin
                    r_state <= S_TWR;
                end
                S_TWR: begin
                    r_waiting[r_tgt] <= 1'b0;
                    r_state          <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_valid = r_out.valid;
    assign o_result_proc  = r_out.pid;

    // A result without a process id reports zero in its place.
    a_proc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_valid |-> o_result_proc == '0)
        else $error("result beat without a process carries a nonzero id");

    // Any failure status comes without a process.
    a_fail_no_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> !o_result_valid)
        else $error("failed operation reports a process");

    // The unused status code never leaves the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != ST_UNUSED)
        else $error("undefined status code on output");

    // Memories change only while an operation is in progress.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we || link_wr.en |-> r_state != S_IDLE && r_state != S_FIN)
        else $error("memory write outside an operation");

    // A taken beat always moves the sequencer out of idle.
    a_accept_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !(r_state == S_IDLE))
        else $error("accepted beat did not start an operation");

endmodule
